// ----- hw/rtl/windowed_throughput_meter_top_macros.svh -----
// Assertion macros for the windowed throughput meter
`ifndef WINDOWED_THROUGHPUT_METER_TOP_MACROS_SVH
`define WINDOWED_THROUGHPUT_METER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// implication checked at every clock edge out of reset
`define WTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// condition must never hold out of reset
`define WTM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define WTM_ASSERT_IMP(lbl, ante, cons)
`define WTM_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- hw/rtl/wtm_pkg.sv -----
// Shared types and constants of the windowed throughput meter
package wtm_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int TIME_W    = 32;
  localparam int BYTES_W   = 48;
  localparam int WIN_W     = 32;
  localparam int NUM_W     = 80;
  localparam int DEN_W     = 58;
  localparam int CFG_IDX_W = 1;

  localparam logic [9:0]         MS_PER_S    = 10'd1000;
  localparam logic [NUM_W-1:0]   RATE_CAP    = 80'h0000_0000_FFFF_FFFF_FFFF;
  localparam logic [NUM_W-1:0]   REM_POS_CAP = 80'h0000_0000_7FFF_FFFF_FFFF;
  localparam logic [NUM_W-1:0]   REM_NEG_CAP = 80'h0000_0000_8000_0000_0000;
  localparam logic [WIN_W-1:0]   REM_WIN_RST  = 32'd10000;
  localparam logic [WIN_W-1:0]   RATE_WIN_RST = 32'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_REM_WIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WIN = 1'd1;

  typedef struct packed {
    logic [TIME_W-1:0]         time_ms;
    logic [BYTES_W-1:0]        bytes_done;
    logic signed [BYTES_W-1:0] bytes_left;
  } wtm_in_t;

  typedef struct packed {
    logic [BYTES_W-1:0]        rate_bytes_per_sec;
    logic                      rate_valid;
    logic signed [BYTES_W-1:0] remaining_sec;
    logic                      remaining_valid;
  } wtm_out_t;

  // item after classification in the front part
  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [BYTES_W-1:0] bytes_done;
    logic [BYTES_W-1:0] left_mag;
    logic               left_neg;
  } wtm_cls_t;

  typedef struct packed {
    logic ring_empty;
    logic scanning;
  } wtm_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_TRIM,
    S_PREP,
    S_PREP2,
    S_PREP3,
    S_RATE_GO,
    S_RATE_WAIT,
    S_REM_GO,
    S_REM_WAIT,
    S_DONE
  } wtm_state_t;

endpackage

// ----- hw/rtl/wtm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module wtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/wtm_front.sv -----
// Front part: takes items, splits the remaining bytes into sign and magnitude, queues them
module wtm_front
  import wtm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wtm_in_t  in_data,
  input  logic     pop,
  output logic     q_valid,
  output wtm_cls_t q_item
);

  wtm_cls_t   mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  wtm_cls_t   cls;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    cls.time_ms    = in_data.time_ms;
    cls.bytes_done = in_data.bytes_done;
    cls.left_neg   = in_data.bytes_left[BYTES_W-1];
    cls.left_mag   = cls.left_neg ? (~in_data.bytes_left + 48'd1) : in_data.bytes_left;
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop && q_valid) begin
      rp_nxt = ~rp_r;
    end
    case ({push, pop && q_valid})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

// ----- hw/rtl/wtm_div.sv -----
// Restoring divider, one quotient bit per cycle
module wtm_div
  import wtm_pkg::*;
#(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      r2;
  logic [DW:0]      diff;
  logic             ge;

  assign r2   = {rem_r, quo_r[NW-1]};
  assign diff = r2 - {1'b0, den_r};
  assign ge   = (r2 >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
      cnt_nxt = CNT_W'(NW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DW-1:0] : r2[DW-1:0];
      quo_nxt  = {quo_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- hw/rtl/wtm_back.sv -----
// Back part: sample ring, window scan, trim and the two estimates
module wtm_back
  import wtm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIN_W-1:0] rem_win,
  input  logic [WIN_W-1:0] rate_win,
  input  logic             q_valid,
  input  wtm_cls_t         q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output wtm_out_t         out_data,
  output wtm_stat_t        stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TIME_W + BYTES_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(k);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  wtm_state_t state_r, state_nxt;
  logic [AW-1:0]       oldest_r, oldest_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TIME_W-1:0]   newest_t_r, newest_t_nxt;
  logic [BYTES_W-1:0]  newest_b_r, newest_b_nxt;
  logic                acc_r, acc_nxt;
  logic [BYTES_W-1:0]  left_mag_r, left_mag_nxt;
  logic                left_neg_r, left_neg_nxt;
  logic signed [TIME_W:0] bmax_r, bmax_nxt;
  logic signed [TIME_W:0] brate_r, brate_nxt;
  logic signed [TIME_W:0] brem_r, brem_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]       rd_pos_r, rd_pos_nxt;
  logic [CW-1:0]       cmax_r, cmax_nxt;
  logic [TIME_W-1:0]   frr_t_r, frr_t_nxt, frm_t_r, frm_t_nxt;
  logic [BYTES_W-1:0]  frr_b_r, frr_b_nxt, frm_b_r, frm_b_nxt;
  logic [TIME_W-1:0]   dt_rate_r, dt_rate_nxt, dt_rem_r, dt_rem_nxt;
  logic signed [BYTES_W:0] db_rate_r, db_rate_nxt, db_rem_r, db_rem_nxt;
  logic [DEN_W-1:0]    rate_num_r, rate_num_nxt;
  logic [DEN_W-1:0]    rem_den_r, rem_den_nxt;
  logic [63:0]         lo_r, lo_nxt;
  logic [BYTES_W-1:0]  hi_r, hi_nxt;
  logic [NUM_W-1:0]    rem_num_r, rem_num_nxt;
  logic [BYTES_W-1:0]  rate_q_r, rate_q_nxt;
  logic                rate_v_r, rate_v_nxt;
  logic [BYTES_W-1:0]  rem_q_r, rem_q_nxt;
  logic                rem_v_r, rem_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  wtm_out_t            out_data_r, out_data_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num, div_quo;
  logic [DEN_W-1:0]    div_den;

  logic [TIME_W-1:0]   e_t;
  logic [BYTES_W-1:0]  e_b;
  logic                acc_now;
  logic [WIN_W-1:0]    wmax;
  logic [TIME_W-1:0]   nt;
  logic [BYTES_W:0]    dm;
  logic                neg;
  logic [NUM_W-1:0]    cap;
  logic [NUM_W-1:0]    mag;

  assign e_t = ram_rdata[EW-1:BYTES_W];
  assign e_b = ram_rdata[BYTES_W-1:0];

  wtm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wtm_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    acc_now = (count_r == '0) || (q_item.time_ms > newest_t_r);
    wmax    = (rem_win > rate_win) ? rem_win : rate_win;
    nt      = acc_now ? q_item.time_ms : newest_t_r;
    dm      = db_rem_r[BYTES_W] ? (~db_rem_r + 49'd1) : db_rem_r;
    neg     = left_neg_r ^ db_rem_r[BYTES_W];
    cap     = neg ? REM_NEG_CAP : REM_POS_CAP;
    mag     = (div_quo > cap) ? cap : div_quo;
  end

  always_comb begin
    state_nxt    = state_r;
    oldest_nxt   = oldest_r;
    count_nxt    = count_r;
    newest_t_nxt = newest_t_r;
    newest_b_nxt = newest_b_r;
    acc_nxt      = acc_r;
    left_mag_nxt = left_mag_r;
    left_neg_nxt = left_neg_r;
    bmax_nxt     = bmax_r;
    brate_nxt    = brate_r;
    brem_nxt     = brem_r;
    iss_nxt      = iss_r;
    rd_vld_nxt   = 1'b0;
    rd_pos_nxt   = rd_pos_r;
    cmax_nxt     = cmax_r;
    frr_t_nxt    = frr_t_r;
    frr_b_nxt    = frr_b_r;
    frm_t_nxt    = frm_t_r;
    frm_b_nxt    = frm_b_r;
    dt_rate_nxt  = dt_rate_r;
    db_rate_nxt  = db_rate_r;
    dt_rem_nxt   = dt_rem_r;
    db_rem_nxt   = db_rem_r;
    rate_num_nxt = rate_num_r;
    rem_den_nxt  = rem_den_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    rem_num_nxt  = rem_num_r;
    rate_q_nxt   = rate_q_r;
    rate_v_nxt   = rate_v_r;
    rem_q_nxt    = rem_q_r;
    rem_v_nxt    = rem_v_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_of(oldest_r, count_r);
    ram_wdata = {q_item.time_ms, q_item.bytes_done};
    ram_raddr = slot_of(oldest_r, iss_r);
    div_start = 1'b0;
    div_num   = rem_num_r;
    div_den   = rem_den_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop          = 1'b1;
          acc_nxt      = acc_now;
          left_mag_nxt = q_item.left_mag;
          left_neg_nxt = q_item.left_neg;
          bmax_nxt     = $signed({1'b0, q_item.time_ms}) - $signed({1'b0, wmax});
          brate_nxt    = $signed({1'b0, nt}) - $signed({1'b0, rate_win});
          brem_nxt     = $signed({1'b0, nt}) - $signed({1'b0, rem_win});
          if (acc_now) begin
            ram_we       = 1'b1;
            newest_t_nxt = q_item.time_ms;
            newest_b_nxt = q_item.bytes_done;
            if (count_r == CW'(DEPTH)) begin
              // ring full: overwrite the oldest entry
              ram_waddr  = oldest_r;
              oldest_nxt = slot_of(oldest_r, CW'(1));
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end
          iss_nxt   = '0;
          cmax_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_r < count_r) begin
          iss_nxt    = iss_r + CW'(1);
          rd_vld_nxt = 1'b1;
          rd_pos_nxt = iss_r;
        end
        if (rd_vld_r) begin
          if ($signed({1'b0, e_t}) <= bmax_r) begin
            cmax_nxt = cmax_r + CW'(1);
          end
          // front: newest entry at or before the bound, else the oldest
          if (rd_pos_r == '0 || $signed({1'b0, e_t}) <= brate_r) begin
            frr_t_nxt = e_t;
            frr_b_nxt = e_b;
          end
          if (rd_pos_r == '0 || $signed({1'b0, e_t}) <= brem_r) begin
            frm_t_nxt = e_t;
            frm_b_nxt = e_b;
          end
          if (rd_pos_r == count_r - CW'(1)) begin
            state_nxt = S_TRIM;
          end
        end
      end
      S_TRIM: begin
        // keep only the newest entry at or before the widest bound
        if (acc_r && cmax_r >= CW'(2)) begin
          oldest_nxt = slot_of(oldest_r, cmax_r - CW'(1));
          count_nxt  = count_r - (cmax_r - CW'(1));
        end
        dt_rate_nxt = newest_t_r - frr_t_r;
        db_rate_nxt = $signed({1'b0, newest_b_r}) - $signed({1'b0, frr_b_r});
        dt_rem_nxt  = newest_t_r - frm_t_r;
        db_rem_nxt  = $signed({1'b0, newest_b_r}) - $signed({1'b0, frm_b_r});
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        rate_num_nxt = DEN_W'(db_rate_r[BYTES_W-1:0]) * DEN_W'(MS_PER_S);
        rem_den_nxt  = DEN_W'(dm[BYTES_W-1:0]) * DEN_W'(MS_PER_S);
        lo_nxt       = 64'(left_mag_r[31:0]) * 64'(dt_rem_r);
        state_nxt    = S_PREP2;
      end
      S_PREP2: begin
        hi_nxt    = BYTES_W'(left_mag_r[BYTES_W-1:32]) * BYTES_W'(dt_rem_r);
        state_nxt = S_PREP3;
      end
      S_PREP3: begin
        rem_num_nxt = NUM_W'(lo_r) + {hi_r, 32'd0};
        state_nxt   = S_RATE_GO;
      end
      S_RATE_GO: begin
        if (dt_rate_r != '0 && !db_rate_r[BYTES_W] && db_rate_r != '0) begin
          div_start = 1'b1;
          div_num   = NUM_W'(rate_num_r);
          div_den   = DEN_W'(dt_rate_r);
          state_nxt = S_RATE_WAIT;
        end else begin
          rate_q_nxt = '0;
          rate_v_nxt = 1'b0;
          state_nxt  = S_REM_GO;
        end
      end
      S_RATE_WAIT: begin
        if (div_done) begin
          rate_q_nxt = (div_quo > RATE_CAP) ? RATE_CAP[BYTES_W-1:0] : div_quo[BYTES_W-1:0];
          rate_v_nxt = 1'b1;
          state_nxt  = S_REM_GO;
        end
      end
      S_REM_GO: begin
        if (db_rem_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_REM_WAIT;
        end else begin
          rem_q_nxt = '0;
          rem_v_nxt = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_REM_WAIT: begin
        if (div_done) begin
          rem_q_nxt = neg ? (~mag[BYTES_W-1:0] + 48'd1) : mag[BYTES_W-1:0];
          rem_v_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.rate_bytes_per_sec = rate_q_r;
          out_data_nxt.rate_valid         = rate_v_r;
          out_data_nxt.remaining_sec      = rem_q_r;
          out_data_nxt.remaining_valid    = rem_v_r;
          state_nxt                       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_t_r <= newest_t_nxt;
    newest_b_r <= newest_b_nxt;
    acc_r      <= acc_nxt;
    left_mag_r <= left_mag_nxt;
    left_neg_r <= left_neg_nxt;
    bmax_r     <= bmax_nxt;
    brate_r    <= brate_nxt;
    brem_r     <= brem_nxt;
    iss_r      <= iss_nxt;
    rd_pos_r   <= rd_pos_nxt;
    cmax_r     <= cmax_nxt;
    frr_t_r    <= frr_t_nxt;
    frr_b_r    <= frr_b_nxt;
    frm_t_r    <= frm_t_nxt;
    frm_b_r    <= frm_b_nxt;
    dt_rate_r  <= dt_rate_nxt;
    db_rate_r  <= db_rate_nxt;
    dt_rem_r   <= dt_rem_nxt;
    db_rem_r   <= db_rem_nxt;
    rate_num_r <= rate_num_nxt;
    rem_den_r  <= rem_den_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rem_num_r  <= rem_num_nxt;
    rate_q_r   <= rate_q_nxt;
    rate_v_r   <= rate_v_nxt;
    rem_q_r    <= rem_q_nxt;
    rem_v_r    <= rem_v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.ring_empty = (count_r == '0);
  assign stat.scanning   = (state_r == S_SCAN);

endmodule

// ----- hw/rtl/windowed_throughput_meter_top.sv -----
// Windowed throughput meter: top level with configuration registers.
// One item at a time: ring scan (N entries held, up to DEPTH), trim and products, then up to
// two divisions in one shared divider, and loading of the result into the output register.
// A new item leaves the queue only when the last is through; two items may wait meanwhile.
// Synchronous reset empties the ring and sets the windows to 10000 ms and 5000 ms.
`include "windowed_throughput_meter_top_macros.svh"

module windowed_throughput_meter_top
  import wtm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wtm_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wtm_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_wdata
);

  logic [WIN_W-1:0] rem_win_r, rem_win_nxt;
  logic [WIN_W-1:0] rate_win_r, rate_win_nxt;
  logic             q_valid;
  logic             pop;
  wtm_cls_t         q_item;
  wtm_stat_t        stat;

  always_comb begin
    rem_win_nxt  = rem_win_r;
    rate_win_nxt = rate_win_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_REM_WIN:  rem_win_nxt  = cfg_wdata;
        REG_RATE_WIN: rate_win_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_win_r  <= REM_WIN_RST;
      rate_win_r <= RATE_WIN_RST;
    end else begin
      rem_win_r  <= rem_win_nxt;
      rate_win_r <= rate_win_nxt;
    end
  end

  wtm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  wtm_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rem_win   (rem_win_r),
    .rate_win  (rate_win_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

  `WTM_ASSERT_IMP(a_rate_zero_when_invalid, out_valid && !out_data.rate_valid, out_data.rate_bytes_per_sec == '0)
  `WTM_ASSERT_IMP(a_rem_zero_when_invalid, out_valid && !out_data.remaining_valid, out_data.remaining_sec == '0)
  `WTM_ASSERT_NEVER(a_scan_on_empty_ring, stat.scanning && stat.ring_empty)
  `WTM_ASSERT_NEVER(a_result_with_empty_ring, out_valid && stat.ring_empty)

endmodule
